// File: hw/rtl/rhc_pkg.sv
// Package: shared constants for the RGB to HSL converter.
`timescale 1ns / 1ps
package rhc_pkg;
  // Sector codes for which channel holds the maximum.
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;
endpackage

// File: hw/rtl/rhc_stream_if.sv
// Interface: valid/ready stream channel with a generic payload.
`timescale 1ns / 1ps
interface rhc_stream_if #(
  parameter int W = 24
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/rhc_div_cell.sv
// Module: restoring-division cell; one quotient bit per cycle while enabled.
`timescale 1ns / 1ps
module rhc_div_cell #(
  parameter int NW = 12,
  parameter int DW = 12,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rem_in,
  input  logic [DW-1:0] den_in,
  input  logic [QW-1:0] quo_in,
  output logic [NW-1:0] rem_r,
  output logic [DW-1:0] den_r,
  output logic [QW-1:0] quo_r
);
  logic [NW:0] shifted;
  logic [NW:0] diff;
  logic        take;

  always_comb begin
    shifted = {rem_in, 1'b0};
    diff    = shifted - {{(NW+1-DW){1'b0}}, den_in};
    take    = (shifted >= {{(NW+1-DW){1'b0}}, den_in});
  end

  // Payload only; advance when the row advances.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= take ? diff[NW-1:0] : shifted[NW-1:0];
      den_r <= den_in;
      quo_r <= {quo_in[QW-2:0], take};
    end
  end
endmodule

// File: hw/rtl/rhc_divider.sv
// Module: row of division cells computing floor(num * 2^STEPS / den) for num < den.
`timescale 1ns / 1ps
module rhc_divider #(
  parameter int NW = 12,
  parameter int DW = 12,
  parameter int QW = 17,
  parameter int STEPS = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  logic [NW-1:0] rem_s [STEPS+1];
  logic [DW-1:0] den_s [STEPS+1];
  logic [QW-1:0] quo_s [STEPS+1];

  assign rem_s[0] = num;
  assign den_s[0] = den;
  assign quo_s[0] = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    rhc_div_cell #(.NW(NW), .DW(DW), .QW(QW)) u_cell (
      .clk(clk), .en(en),
      .rem_in(rem_s[i]), .den_in(den_s[i]), .quo_in(quo_s[i]),
      .rem_r(rem_s[i+1]), .den_r(den_s[i+1]), .quo_r(quo_s[i+1])
    );
  end

  assign quo = quo_s[STEPS];
endmodule

// File: hw/rtl/rgb_to_hsl_converter_core.sv
// Top level: pipelined RGB to HSL converter.
// Stages: one prep stage, then FRAC_BITS + 1 division cells; the last cell drives the output.
// Throughput: one pixel per cycle while the pipe is not stalled; three rows of division
// cells, one quotient bit per cell. The whole pipe advances together; it stalls only when
// the output register is full and not taken. Reset (rst_n low, synchronous) clears all
// valid bits; payload holds garbage.
`timescale 1ns / 1ps
module rgb_to_hsl_converter_core #(
  parameter int FRAC_BITS    = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  rhc_stream_if.sink   in_ch,
  rhc_stream_if.source out_ch
);
  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRAC_BITS;
  // Denominators are doubled so every numerator stays strictly below its denominator;
  // the largest, 12*CMAX, needs CB+4 bits.
  localparam int NW = CB + 4;
  localparam int DW = CB + 4;
  localparam int QW = FB + 1;
  localparam int STEPS = FB + 1;
  // Total valid-pipe depth: one prep stage and STEPS cell stages; the last cell is the output.
  localparam int DEPTH = STEPS + 1;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  logic en;
  logic [DEPTH-1:0] vld_r, vld_nxt;

  // Advance whenever the output slot is free or being taken.
  assign en = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  // ---- Prep stage: max/min, sector numerator ----
  logic [CB-1:0] r, g, b, mx, mn;
  logic [CB:0]   sum;
  logic [CB-1:0] d;
  logic [1:0]    sec;
  logic [NW-1:0] hnum, snum, lnum;
  logic [DW-1:0] hden, sden, lden;
  logic          grey;

  always_comb begin
    r = in_ch.data[CB-1:0];
    g = in_ch.data[CB +: CB];
    b = in_ch.data[2*CB +: CB];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = {1'b0, mx} + {1'b0, mn};
    d = mx - mn;
    grey = (d == '0);
    if (mx == r) sec = rhc_pkg::SEC_RED;
    else if (mx == g) sec = rhc_pkg::SEC_GREEN;
    else sec = rhc_pkg::SEC_BLUE;
    case (sec)
      rhc_pkg::SEC_RED:
        hnum = (g < b) ? (NW'(g) + NW'(6) * NW'(d) - NW'(b)) : (NW'(g) - NW'(b));
      rhc_pkg::SEC_GREEN: hnum = NW'(b) + NW'(2) * NW'(d) - NW'(r);
      default:            hnum = NW'(r) + NW'(4) * NW'(d) - NW'(g);
    endcase
    // Twice 6*d: the row then yields floor(num * 2^FB / (6*d)).
    hden = DW'(12) * DW'(d);
    snum = NW'(d);
    // Grey pixels: force a zero numerator; any nonzero denominator gives 0.
    if (grey) begin
      hnum = '0; hden = DW'(1); sden = DW'(1);
    end else if (sum > {1'b0, CMAX}) begin
      sden = (DW'(2) * DW'(CMAX) - DW'(sum)) << 1;
    end else begin
      sden = DW'(sum) << 1;
    end
    lnum = NW'(sum);
    lden = DW'(4) * DW'(CMAX);
  end

  logic [NW-1:0] hnum_r, snum_r, lnum_r;
  logic [DW-1:0] hden_r, sden_r, lden_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hnum_r <= hnum; hden_r <= hden;
      snum_r <= snum; sden_r <= sden;
      lnum_r <= lnum; lden_r <= lden;
    end
  end

  // ---- Division rows ----
  logic [QW-1:0] hq, sq, lq;
  rhc_divider #(.NW(NW), .DW(DW), .QW(QW), .STEPS(STEPS)) u_hue (
    .clk(clk), .en(en), .num(hnum_r), .den(hden_r), .quo(hq));
  rhc_divider #(.NW(NW), .DW(DW), .QW(QW), .STEPS(STEPS)) u_sat (
    .clk(clk), .en(en), .num(snum_r), .den(sden_r), .quo(sq));
  rhc_divider #(.NW(NW), .DW(DW), .QW(QW), .STEPS(STEPS)) u_light (
    .clk(clk), .en(en), .num(lnum_r), .den(lden_r), .quo(lq));

  // Quotient bit k is produced by cell k with weight 2^(STEPS-1-k); each row yields
  // floor(num * 2^STEPS / (2*den)) = floor(num * 2^FB / den), up to 2^FB when num == den.
  // ---- Valid pipe ----
  always_comb begin
    vld_nxt = vld_r;
    if (en) vld_nxt = {vld_r[DEPTH-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  assign out_ch.valid = vld_r[DEPTH-1];
  assign out_ch.data  = {lq, sq, hq[FB-1:0]};
endmodule

// File: hw/rtl/rhc_checker.sv
// Checker: port-level properties of the converter, bound to the top level.
`timescale 1ns / 1ps
module rhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [49:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data[49:33] <= 17'h10000) else $error("lightness over full scale");
endmodule

bind rgb_to_hsl_converter_core rhc_checker u_rhc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
